// File: rtl/mp2d_pkg.sv
// Shared types, constants and a helper function for the 2-D max pooling block.
`default_nettype none
package mp2d_pkg;
	localparam int MAX_WIDTH = 64;
	localparam int MAX_CHANNELS = 16;
	localparam int MAX_WINDOW = 4;
	localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH * MAX_CHANNELS;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int RING_W = $clog2(MAX_WINDOW);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CH_W = $clog2(MAX_CHANNELS);
	localparam int ROW_W = 10;
	localparam int HEIGHT_LIMIT = 1024;

	// Configuration register indexes.
	localparam logic [2:0] REG_IN_WIDTH = 3'd0;
	localparam logic [2:0] REG_IN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CHANNELS = 3'd2;
	localparam logic [2:0] REG_WINDOW_W = 3'd3;
	localparam logic [2:0] REG_WINDOW_H = 3'd4;
	localparam logic [2:0] REG_STRIDE = 3'd5;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Store address from ring row, column and channel.
	function automatic logic [ADDR_W-1:0] store_addr(
		input logic [RING_W-1:0] ring,
		input logic [COL_W-1:0] col,
		input logic [CH_W-1:0] ch
	);
		store_addr = {ring, col, ch};
	endfunction
endpackage
`default_nettype wire

// File: rtl/mp2d_ram.sv
// Single-port-write, single-port-read line store with registered read data.
`default_nettype none
module mp2d_ram
	import mp2d_pkg::*;
(
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [ADDR_W-1:0] wr_addr,
	input wire logic [15:0] wr_data,
	input wire logic [ADDR_W-1:0] rd_addr,
	output logic [15:0] rd_data
);
	logic [15:0] mem [STORE_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// File: rtl/max_pool_2d_stream.sv
// Top level of the streaming 2-D max pooling block.
// Result: a closing sample gives its result once the window scan has finished and
// the result register is free; other samples give no result.
// Input: a non-closing sample does not hold the input; a closing one holds it until
// its result is loaded, with one store read per window element.
// Reset: asynchronous, clears counters and control, sets config to defaults; store and payload kept.
`default_nettype none
module max_pool_2d_stream
	import mp2d_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [15:0] sample,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [15:0] pooled_value,
	output logic [3:0] argmax_pos,
	output logic [3:0] chan_index,
	output logic [5:0] out_col,
	output logic [9:0] out_row,
	output logic frame_done,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	// Configuration registers.
	logic [6:0] in_width_q;
	logic [10:0] in_height_q;
	logic [4:0] channels_q;
	logic [2:0] window_w_q, window_h_q, stride_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CH_W-1:0] ch_q;
	state_t state_q, state_d;

	// Effective sizes.
	logic [6:0] w_eff;
	logic [10:0] h_eff;
	logic [4:0] nc_eff;
	logic [2:0] ww_eff, wh_eff, st_eff;
	always_comb begin
		w_eff = (in_width_q == 7'd0) ? 7'd1 :
			(in_width_q > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : in_width_q;
		h_eff = (in_height_q == 11'd0) ? 11'd1 :
			(in_height_q > 11'(HEIGHT_LIMIT)) ? 11'(HEIGHT_LIMIT) : in_height_q;
		nc_eff = (channels_q == 5'd0) ? 5'd1 :
			(channels_q > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : channels_q;
		ww_eff = (window_w_q == 3'd0) ? 3'd1 :
			(window_w_q > 3'(MAX_WINDOW)) ? 3'(MAX_WINDOW) : window_w_q;
		if ({4'd0, ww_eff} > w_eff) ww_eff = w_eff[2:0];
		wh_eff = (window_h_q == 3'd0) ? 3'd1 :
			(window_h_q > 3'(MAX_WINDOW)) ? 3'(MAX_WINDOW) : window_h_q;
		if ({8'd0, wh_eff} > h_eff) wh_eff = h_eff[2:0];
		st_eff = (stride_q == 3'd0) ? 3'd1 : stride_q;
	end

	// Current position, pulled back into the frame.
	logic [COL_W-1:0] c_cur;
	logic [ROW_W-1:0] r_cur;
	logic [CH_W-1:0] ch_cur;
	assign c_cur = ({1'b0, col_q} < w_eff) ? col_q : '0;
	assign r_cur = ({1'b0, row_q} < h_eff) ? row_q : '0;
	assign ch_cur = ({1'b0, ch_q} < nc_eff) ? ch_q : '0;

	// Window end and origin, worked out from the current position per axis.
	logic [COL_W:0] c_end;
	logic [ROW_W:0] r_end;
	logic [COL_W:0] c0;
	logic [ROW_W:0] r0;
	assign c_end = {1'b0, c_cur} + 1'b1;
	assign r_end = {1'b0, r_cur} + 1'b1;
	assign c0 = c_end - {4'd0, ww_eff};
	assign r0 = r_end - {8'd0, wh_eff};

	// Stride phase counters and output indexes kept alongside position.
	logic [2:0] cph_q, rph_q;
	logic [COL_W-1:0] oc_q;
	logic [ROW_W-1:0] or_q;
	logic closing;
	assign closing = (c_end >= {4'd0, ww_eff}) && (r_end >= {8'd0, wh_eff})
		&& (cph_q == 3'd0) && (rph_q == 3'd0);

	// Last output indexes, worked out by a small stride divider table.
	logic [COL_W-1:0] last_oc;
	logic [ROW_W-1:0] last_or;
	logic [6:0] cspan;
	logic [10:0] rspan;
	assign cspan = w_eff - {4'd0, ww_eff};
	assign rspan = h_eff - {8'd0, wh_eff};
	always_comb begin
		unique case (st_eff)
			3'd1: begin last_oc = cspan[5:0]; last_or = rspan[9:0]; end
			3'd2: begin last_oc = 6'(cspan >> 1); last_or = 10'(rspan >> 1); end
			3'd4: begin last_oc = 6'(cspan >> 2); last_or = 10'(rspan >> 2); end
			3'd3: begin
				last_oc = 6'((14'(cspan) * 14'd171) >> 9);
				last_or = 10'((22'(rspan) * 22'd1366) >> 12);
			end
			3'd5: begin
				last_oc = 6'((14'(cspan) * 14'd205) >> 10);
				last_or = 10'((22'(rspan) * 22'd3277) >> 14);
			end
			3'd6: begin
				last_oc = 6'((14'(cspan) * 14'd171) >> 10);
				last_or = 10'((22'(rspan) * 22'd1366) >> 13);
			end
			default: begin
				last_oc = 6'((14'(cspan) * 14'd293) >> 11);
				last_or = 10'((22'(rspan) * 22'd2341) >> 14);
			end
		endcase
	end

	// Scan registers.
	logic [ADDR_W-1:0] rd_addr;
	logic [15:0] rd_data;
	logic [1:0] si_q, sj_q;
	logic [COL_W-1:0] sc0_q;
	logic [RING_W-1:0] sr0_q;
	logic [CH_W-1:0] sch_q;
	logic rd_vld_s1;
	logic [3:0] rd_pos_s1;
	logic [3:0] pos_q;
	logic last_rd_q, last_rd_s1;
	logic signed [15:0] best_q;
	logic [3:0] best_pos_q;
	logic have_q;
	logic [COL_W-1:0] roc_q;
	logic [ROW_W-1:0] ror_q;
	logic rfd_q;

	// Result register, so the input can move on while a result waits.
	logic out_valid_q;
	logic signed [15:0] res_value_q;
	logic [3:0] res_pos_q;
	logic [CH_W-1:0] res_chan_q;
	logic [COL_W-1:0] res_col_q;
	logic [ROW_W-1:0] res_row_q;
	logic res_done_q;

	logic in_acc, out_acc, cfg_acc, wr_en, load_out, scan_step;
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign wr_en = in_acc;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign scan_step = (state_q == ST_SCAN) && !last_rd_q;

	logic scan_last;
	assign scan_last = ({1'b0, sj_q} == ww_eff - 3'd1) && ({1'b0, si_q} == wh_eff - 3'd1);
	assign rd_addr = store_addr(RING_W'(sr0_q + RING_W'(si_q)), sc0_q + COL_W'(sj_q), sch_q);

	mp2d_ram u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(store_addr(r_cur[RING_W-1:0], c_cur, ch_cur)),
		.wr_data(sample),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && closing) state_d = ST_SCAN;
			ST_SCAN: if (rd_vld_s1 && last_rd_s1) state_d = ST_DONE;
			ST_DONE: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration, counters and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q <= 7'd8; in_height_q <= 11'd8; channels_q <= 5'd1;
			window_w_q <= 3'd2; window_h_q <= 3'd2; stride_q <= 3'd2;
			col_q <= '0; row_q <= '0; ch_q <= '0;
			cph_q <= '0; rph_q <= '0; oc_q <= '0; or_q <= '0;
			rd_vld_s1 <= 1'b0; last_rd_s1 <= 1'b0; last_rd_q <= 1'b0;
			si_q <= '0; sj_q <= '0; pos_q <= '0; have_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_IN_WIDTH: in_width_q <= cfg_data[6:0];
					REG_IN_HEIGHT: in_height_q <= cfg_data[10:0];
					REG_CHANNELS: channels_q <= cfg_data[4:0];
					REG_WINDOW_W: window_w_q <= cfg_data[2:0];
					REG_WINDOW_H: window_h_q <= cfg_data[2:0];
					REG_STRIDE: stride_q <= cfg_data[2:0];
					default: ;
				endcase
				if (cfg_index <= REG_STRIDE) begin
					col_q <= '0; row_q <= '0; ch_q <= '0;
					cph_q <= '0; rph_q <= '0; oc_q <= '0; or_q <= '0;
				end
			end else if (in_acc) begin
				// Advance position and stride phases.
				if ({1'b0, ch_cur} + 5'd1 >= nc_eff) begin
					ch_q <= '0;
					if ({1'b0, c_cur} + 7'd1 >= w_eff) begin
						col_q <= '0; cph_q <= '0; oc_q <= '0;
						if ({1'b0, r_cur} + 11'd1 >= h_eff) begin
							row_q <= '0; rph_q <= '0; or_q <= '0;
						end else begin
							row_q <= r_cur + 1'b1;
							if (r_end >= {8'd0, wh_eff}) begin
								if (rph_q + 3'd1 >= st_eff) begin
									rph_q <= '0; or_q <= or_q + 1'b1;
								end else begin
									rph_q <= rph_q + 3'd1;
								end
							end
						end
					end else begin
						col_q <= c_cur + 1'b1;
						if (c_end >= {4'd0, ww_eff}) begin
							if (cph_q + 3'd1 >= st_eff) begin
								cph_q <= '0; oc_q <= oc_q + 1'b1;
							end else begin
								cph_q <= cph_q + 3'd1;
							end
						end
					end
				end else begin
					ch_q <= ch_cur + 1'b1;
				end
			end
			// Scan walks the window one store read per cycle.
			rd_vld_s1 <= scan_step;
			if (in_acc && closing) begin
				si_q <= '0; sj_q <= '0; pos_q <= '0; last_rd_q <= 1'b0;
			end else if (scan_step) begin
				rd_pos_s1 <= pos_q;
				last_rd_s1 <= scan_last;
				last_rd_q <= scan_last;
				pos_q <= pos_q + 4'd1;
				if ({1'b0, sj_q} == ww_eff - 3'd1) begin
					sj_q <= '0; si_q <= si_q + 2'd1;
				end else begin
					sj_q <= sj_q + 2'd1;
				end
			end
			if (in_acc && closing) begin
				have_q <= 1'b0;
			end else if (rd_vld_s1) begin
				have_q <= 1'b1;
			end
		end
	end

	// The result register fills after a scan and empties on its transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc && closing) begin
			sc0_q <= c0[COL_W-1:0];
			sr0_q <= r0[RING_W-1:0];
			sch_q <= ch_cur;
			roc_q <= oc_q;
			ror_q <= or_q;
			rfd_q <= (oc_q == last_oc) && (or_q == last_or) && ({1'b0, ch_cur} == nc_eff - 5'd1);
		end
		if (rd_vld_s1 && (!have_q || $signed(rd_data) > best_q)) begin
			best_q <= $signed(rd_data);
			best_pos_q <= rd_pos_s1;
		end
		if (load_out) begin
			res_value_q <= best_q;
			res_pos_q <= best_pos_q;
			res_chan_q <= sch_q;
			res_col_q <= roc_q;
			res_row_q <= ror_q;
			res_done_q <= rfd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pooled_value = res_value_q;
	assign argmax_pos = res_pos_q;
	assign chan_index = res_chan_q;
	assign out_col = res_col_q;
	assign out_row = res_row_q;
	assign frame_done = res_done_q;

	// No new sample while a window is scanned or waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("input taken while busy");
	// A result appears only after a finished scan.
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE) else $error("result without scan");
	// A held result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pooled_value) && $stable(argmax_pos))
		else $error("result changed while held");
endmodule
`default_nettype wire
